// ===== rtl/bgd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge package
// Beat types, register map, status codes and the sequencer microprogram.
// ----------------------------------------------------------------------------
package bgd_pkg;

	// field and datapath widths
	localparam int MV_W       = 16;
	localparam int PCT_W      = 7;
	localparam int REP_W      = 8;
	localparam int CODE_W     = 10;
	localparam int REFMV_W    = 12;
	localparam int RES_W      = 16;
	localparam int FS_W       = 16;
	localparam int SUPPLY_W   = 28;
	localparam int TAP_W      = 22;
	localparam int RSUM_W     = 17;
	localparam int PROD_W     = 40;
	localparam int DIVR_W     = 16;
	localparam int MULA_W     = 22;
	localparam int MULB_W     = 28;
	localparam int PC_W       = 4;
	localparam int CNT_W      = 5;
	localparam int SHAMT_W    = 6;
	localparam int RUN_W      = 8;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 16;

	// register map
	localparam logic [CFG_ADDR_W-1:0] REG_MIN_MV        = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_MV        = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_REFERENCE_MV  = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_UPPER_RES     = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_LOWER_RES     = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] REG_ADC_MIN_VALID = 3'd5;

	// result status codes
	localparam logic [1:0] ST_USB     = 2'd0;
	localparam logic [1:0] ST_ACCEPT  = 2'd1;
	localparam logic [1:0] ST_PENDING = 2'd2;
	localparam logic [1:0] ST_REJECT  = 2'd3;

	// fixed values
	localparam logic [PCT_W-1:0] PCT_FULL   = 7'd100;
	localparam logic [PCT_W-1:0] PCT_EMPTY  = 7'd0;
	localparam logic [REP_W-1:0] CAND_NONE  = 8'hFF;
	localparam logic [REP_W-1:0] REP_NONE   = 8'hFF;
	localparam logic [RUN_W-1:0] RUN_MAX    = 8'hFF;
	localparam logic [RUN_W-1:0] RUN_FIRST  = 8'd2;
	localparam logic [RUN_W-1:0] RUN_NEXT   = 8'd3;

	typedef struct packed {
		logic              usb_powered;
		logic [CODE_W-1:0] battery_code;
		logic [CODE_W-1:0] reference_code;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]       status;
		logic             level_changed;
		logic [REP_W-1:0] reported_percent;
		logic [MV_W-1:0]  battery_millivolts;
	} out_beat_t;

	typedef struct packed {
		logic [MV_W-1:0]    min_mv;
		logic [MV_W-1:0]    max_mv;
		logic [REFMV_W-1:0] reference_mv;
		logic [RES_W-1:0]   upper_resistor;
		logic [RES_W-1:0]   lower_resistor;
		logic [CODE_W-1:0]  adc_min_valid;
	} cfg_t;

	// microcode
	typedef enum logic [3:0] {
		OP_FETCH,
		OP_TEST_USB,
		OP_TEST_REJ,
		OP_MUL,
		OP_DIV,
		OP_CLAMP,
		OP_DEBOUNCE,
		OP_USB,
		OP_REJECT,
		OP_EMIT
	} op_t;

	// multiplier operand pairs
	typedef enum logic [1:0] {
		MUL_SUPPLY,
		MUL_TAP,
		MUL_MV,
		MUL_PCT
	} mul_sel_t;

	// divisor, which also picks where the quotient lands
	typedef enum logic [1:0] {
		DIV_BY_REF,
		DIV_BY_FS,
		DIV_BY_LOWER,
		DIV_BY_RANGE
	} div_sel_t;

	typedef struct packed {
		op_t              op;
		mul_sel_t         mul_sel;
		div_sel_t         div_sel;
		logic [CNT_W-1:0] div_cycles;
		logic [PC_W-1:0]  target;
	} ctrl_word_t;

	typedef struct packed {
		logic div_done;
		logic clamp_hit;
	} dp_stat_t;

	// program entry points
	localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
	localparam logic [PC_W-1:0] PC_DEBOUNCE = 4'd12;
	localparam logic [PC_W-1:0] PC_USB      = 4'd13;
	localparam logic [PC_W-1:0] PC_REJECT   = 4'd14;
	localparam logic [PC_W-1:0] PC_EMIT     = 4'd15;

	function automatic ctrl_word_t mk_cw(op_t op, mul_sel_t ms, div_sel_t ds,
			logic [CNT_W-1:0] cyc, logic [PC_W-1:0] tgt);
		ctrl_word_t w;
		w.op         = op;
		w.mul_sel    = ms;
		w.div_sel    = ds;
		w.div_cycles = cyc;
		w.target     = tgt;
		return w;
	endfunction

	// control store, two quotient bits per divide cycle
	function automatic ctrl_word_t ucode(logic [PC_W-1:0] pc);
		ctrl_word_t w;
		case (pc)
			4'd0:    w = mk_cw(OP_FETCH,    MUL_SUPPLY, DIV_BY_REF,   5'd0,  PC_FETCH);
			4'd1:    w = mk_cw(OP_TEST_USB, MUL_SUPPLY, DIV_BY_REF,   5'd0,  PC_USB);
			4'd2:    w = mk_cw(OP_TEST_REJ, MUL_SUPPLY, DIV_BY_REF,   5'd0,  PC_REJECT);
			4'd3:    w = mk_cw(OP_MUL,      MUL_SUPPLY, DIV_BY_REF,   5'd0,  PC_FETCH);
			4'd4:    w = mk_cw(OP_DIV,      MUL_SUPPLY, DIV_BY_REF,   5'd14, PC_FETCH);
			4'd5:    w = mk_cw(OP_MUL,      MUL_TAP,    DIV_BY_FS,    5'd0,  PC_FETCH);
			4'd6:    w = mk_cw(OP_DIV,      MUL_TAP,    DIV_BY_FS,    5'd19, PC_FETCH);
			4'd7:    w = mk_cw(OP_MUL,      MUL_MV,     DIV_BY_LOWER, 5'd0,  PC_FETCH);
			4'd8:    w = mk_cw(OP_DIV,      MUL_MV,     DIV_BY_LOWER, 5'd20, PC_FETCH);
			4'd9:    w = mk_cw(OP_CLAMP,    MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_DEBOUNCE);
			4'd10:   w = mk_cw(OP_MUL,      MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_FETCH);
			4'd11:   w = mk_cw(OP_DIV,      MUL_PCT,    DIV_BY_RANGE, 5'd12, PC_FETCH);
			4'd12:   w = mk_cw(OP_DEBOUNCE, MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_EMIT);
			4'd13:   w = mk_cw(OP_USB,      MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_EMIT);
			4'd14:   w = mk_cw(OP_REJECT,   MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_EMIT);
			4'd15:   w = mk_cw(OP_EMIT,     MUL_PCT,    DIV_BY_RANGE, 5'd0,  PC_FETCH);
			default: w = mk_cw(OP_FETCH,    MUL_SUPPLY, DIV_BY_REF,   5'd0,  PC_FETCH);
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/bgd_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge datapath
// Shared multiplier, shared radix-4 restoring divider and the intermediate
// value registers, all driven by the current control word.
// ----------------------------------------------------------------------------
module bgd_datapath #(
	parameter int ADC_FULL_SCALE = 1023
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bgd_pkg::ctrl_word_t          ctrl,
	input  bgd_pkg::cfg_t                cfg,
	input  logic [bgd_pkg::CODE_W-1:0]   bat,
	input  logic [bgd_pkg::CODE_W-1:0]   refc,
	output bgd_pkg::dp_stat_t            stat,
	output logic [bgd_pkg::MV_W-1:0]     mv,
	output logic [bgd_pkg::PCT_W-1:0]    pct
);
	import bgd_pkg::*;

	localparam logic [FS_W-1:0] FS = FS_W'(ADC_FULL_SCALE);

	logic [PROD_W-1:0]        prod_q;
	logic [SUPPLY_W-1:0]      supply_q;
	logic [TAP_W-1:0]         tap_q;
	logic [MV_W-1:0]          mv_q;
	logic [PCT_W-1:0]         pct_q;
	logic [PROD_W-1:0]        num_q;
	logic [DIVR_W-1:0]        rem_q;
	logic [PROD_W-1:0]        quo_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     busy_q;

	logic [MULA_W-1:0]        mul_a;
	logic [MULB_W-1:0]        mul_b;
	logic [MULA_W+MULB_W-1:0] mul_full;
	logic [RSUM_W-1:0]        rsum;
	logic [MV_W-1:0]          diff;
	logic [DIVR_W-1:0]        divisor;
	logic [SHAMT_W-1:0]       shamt;
	logic [PROD_W-1:0]        num_n;
	logic [DIVR_W-1:0]        rem_n;
	logic [PROD_W-1:0]        quo_n;
	logic [DIVR_W:0]          trial;
	logic                     div_last;
	logic                     at_max;
	logic                     at_min;

	assign rsum = {1'b0, cfg.upper_resistor} + {1'b0, cfg.lower_resistor};
	assign diff = mv_q - cfg.min_mv;

	// multiplier operand select
	always_comb begin
		case (ctrl.mul_sel)
			MUL_SUPPLY: begin
				mul_a = MULA_W'(cfg.reference_mv);
				mul_b = MULB_W'(FS);
			end
			MUL_TAP: begin
				mul_a = MULA_W'(bat);
				mul_b = supply_q;
			end
			MUL_MV: begin
				mul_a = tap_q;
				mul_b = MULB_W'(rsum);
			end
			MUL_PCT: begin
				mul_a = MULA_W'(diff);
				mul_b = MULB_W'(PCT_FULL);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// divisor select
	always_comb begin
		case (ctrl.div_sel)
			DIV_BY_REF:   divisor = DIVR_W'(refc);
			DIV_BY_FS:    divisor = FS;
			DIV_BY_LOWER: divisor = cfg.lower_resistor;
			DIV_BY_RANGE: divisor = cfg.max_mv - cfg.min_mv;
			default:      divisor = FS;
		endcase
	end

	// left-align the dividend so its top bit leads the first cycle
	assign shamt = SHAMT_W'(PROD_W) - {ctrl.div_cycles, 1'b0};

	// two restoring steps per cycle
	always_comb begin
		num_n = num_q;
		rem_n = rem_q;
		quo_n = quo_q;
		trial = '0;
		for (int i = 0; i < 2; i++) begin
			trial = {rem_n, num_n[PROD_W-1]};
			num_n = {num_n[PROD_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				trial = trial - {1'b0, divisor};
				quo_n = {quo_n[PROD_W-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[PROD_W-2:0], 1'b0};
			end
			rem_n = trial[DIVR_W-1:0];
		end
	end

	assign div_last = busy_q && (cnt_q == CNT_W'(1)) && (ctrl.op == OP_DIV);
	assign at_max   = mv_q >= cfg.max_mv;
	assign at_min   = mv_q <= cfg.min_mv;

	// divider sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.op == OP_DIV) begin
			if (!busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= ctrl.div_cycles;
			end else begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_MUL) begin
			prod_q <= mul_full[PROD_W-1:0];
		end
		if (ctrl.op == OP_DIV) begin
			if (!busy_q) begin
				num_q <= prod_q << shamt;
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				num_q <= num_n;
				rem_q <= rem_n;
				quo_q <= quo_n;
			end
		end
		if (div_last) begin
			case (ctrl.div_sel)
				DIV_BY_REF:   supply_q <= quo_n[SUPPLY_W-1:0];
				DIV_BY_FS:    tap_q    <= quo_n[TAP_W-1:0];
				DIV_BY_LOWER: mv_q     <= quo_n[MV_W-1:0];
				DIV_BY_RANGE: pct_q    <= quo_n[PCT_W-1:0];
				default: ;
			endcase
		end
		// saturate at the ends of the scale
		if (ctrl.op == OP_CLAMP) begin
			if (at_max) begin
				pct_q <= PCT_FULL;
			end else if (at_min) begin
				pct_q <= PCT_EMPTY;
			end
		end
	end

	assign stat.div_done  = div_last;
	assign stat.clamp_hit = at_max || at_min;
	assign mv             = mv_q;
	assign pct            = pct_q;

endmodule

// ===== rtl/battery_gauge_with_debounce_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge with debounce
// Converts battery and reference ADC codes to millivolts and a debounced
// percent, under control of a small microprogram.
// ----------------------------------------------------------------------------
// One sample at a time. A USB-powered or rejected sample skips the arithmetic;
// a fully computed sample runs four divisions, and one whose voltage lies at
// or beyond either end of the scale skips the last of them. Sample time is
// set by the single shared divider, which retires two quotient bits per cycle.
// The result sits in an output register, so the next sample is taken as soon
// as the result is loaded there.
// Configuration writes take effect at once and belong between samples.
// ----------------------------------------------------------------------------
module battery_gauge_with_debounce_top #(
	parameter int ADC_FULL_SCALE = 1023
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bgd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [bgd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bgd_pkg::in_beat_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output bgd_pkg::out_beat_t               out_data
);
	import bgd_pkg::*;

	logic [PC_W-1:0]   pc_q;
	logic [PC_W-1:0]   pc_n;
	ctrl_word_t        cw;
	cfg_t              cfg_q;
	logic              usb_q;
	logic [CODE_W-1:0] bat_q;
	logic [CODE_W-1:0] refc_q;
	logic [PCT_W-1:0]  acc_pct_q;
	logic [MV_W-1:0]   stored_mv_q;
	logic              has_valid_q;
	logic [REP_W-1:0]  cand_q;
	logic [RUN_W-1:0]  run_q;
	logic [1:0]        status_q;
	logic              changed_q;
	logic              out_valid_q;
	out_beat_t         out_q;

	dp_stat_t          dp_stat;
	logic [MV_W-1:0]   dp_mv;
	logic [PCT_W-1:0]  dp_pct;
	logic [REP_W-1:0]  pct8;
	logic [RUN_W-1:0]  run_n;
	logic              accept;
	logic              reject;
	logic              out_free;
	logic              in_take;

	assign cw       = ucode(pc_q);
	assign in_ready = (cw.op == OP_FETCH);
	assign in_take  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign reject   = (bat_q < cfg_q.adc_min_valid) || (refc_q == '0)
		|| (cfg_q.lower_resistor == '0);

	bgd_datapath #(
		.ADC_FULL_SCALE(ADC_FULL_SCALE)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cw),
		.cfg    (cfg_q),
		.bat    (bat_q),
		.refc   (refc_q),
		.stat   (dp_stat),
		.mv     (dp_mv),
		.pct    (dp_pct)
	);

	// run length of equal readings and the acceptance decision
	always_comb begin
		pct8 = {1'b0, dp_pct};
		if (pct8 == cand_q) begin
			run_n = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
		end else begin
			run_n = RUN_W'(1);
		end
		accept = has_valid_q ? (run_n >= RUN_NEXT) : (run_n >= RUN_FIRST);
	end

	// next step of the program
	always_comb begin
		case (cw.op)
			OP_FETCH:    pc_n = in_valid ? pc_q + PC_W'(1) : pc_q;
			OP_TEST_USB: pc_n = usb_q ? cw.target : pc_q + PC_W'(1);
			OP_TEST_REJ: pc_n = reject ? cw.target : pc_q + PC_W'(1);
			OP_MUL:      pc_n = pc_q + PC_W'(1);
			OP_DIV:      pc_n = dp_stat.div_done ? pc_q + PC_W'(1) : pc_q;
			OP_CLAMP:    pc_n = dp_stat.clamp_hit ? cw.target : pc_q + PC_W'(1);
			OP_DEBOUNCE: pc_n = cw.target;
			OP_USB:      pc_n = cw.target;
			OP_REJECT:   pc_n = pc_q + PC_W'(1);
			OP_EMIT:     pc_n = out_free ? cw.target : pc_q;
			default:     pc_n = PC_FETCH;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_mv         <= 16'd3300;
			cfg_q.max_mv         <= 16'd4200;
			cfg_q.reference_mv   <= 12'd1210;
			cfg_q.upper_resistor <= 16'd100;
			cfg_q.lower_resistor <= 16'd100;
			cfg_q.adc_min_valid  <= 10'd50;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_MIN_MV:        cfg_q.min_mv         <= cfg_wdata;
				REG_MAX_MV:        cfg_q.max_mv         <= cfg_wdata;
				REG_REFERENCE_MV:  cfg_q.reference_mv   <= cfg_wdata[REFMV_W-1:0];
				REG_UPPER_RES:     cfg_q.upper_resistor <= cfg_wdata;
				REG_LOWER_RES:     cfg_q.lower_resistor <= cfg_wdata;
				REG_ADC_MIN_VALID: cfg_q.adc_min_valid  <= cfg_wdata[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer, gauge state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_FETCH;
			acc_pct_q   <= PCT_FULL;
			stored_mv_q <= '0;
			has_valid_q <= 1'b0;
			cand_q      <= CAND_NONE;
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_n;
			case (cw.op)
				OP_USB: begin
					acc_pct_q   <= PCT_FULL;
					stored_mv_q <= cfg_q.max_mv;
					has_valid_q <= 1'b1;
					cand_q      <= CAND_NONE;
					run_q       <= '0;
				end
				OP_DEBOUNCE: begin
					stored_mv_q <= dp_mv;
					cand_q      <= pct8;
					run_q       <= run_n;
					if (accept) begin
						acc_pct_q   <= dp_pct;
						has_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
			if (cw.op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// input capture, status and result beat
	always_ff @(posedge clk) begin
		if (in_take) begin
			usb_q  <= in_data.usb_powered;
			bat_q  <= in_data.battery_code;
			refc_q <= in_data.reference_code;
		end
		case (cw.op)
			OP_USB: begin
				status_q  <= ST_USB;
				changed_q <= 1'b1;
			end
			OP_DEBOUNCE: begin
				status_q  <= accept ? ST_ACCEPT : ST_PENDING;
				changed_q <= accept;
			end
			OP_REJECT: begin
				status_q  <= ST_REJECT;
				changed_q <= 1'b0;
			end
			default: ;
		endcase
		if (cw.op == OP_EMIT && out_free) begin
			out_q.status             <= status_q;
			out_q.level_changed      <= changed_q;
			out_q.reported_percent   <= has_valid_q ? {1'b0, acc_pct_q} : REP_NONE;
			out_q.battery_millivolts <= stored_mv_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== rtl/bgd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Battery gauge checker
// Port-level properties of the gauge, bound to the top level.
// ----------------------------------------------------------------------------
module bgd_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_wr_en,
	input logic [bgd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input logic [bgd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input logic                             in_valid,
	input logic                             in_ready,
	input bgd_pkg::in_beat_t                in_data,
	input logic                             out_valid,
	input logic                             out_ready,
	input bgd_pkg::out_beat_t               out_data
);
	import bgd_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one sample in flight: no back-to-back input beats
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken twice in a row");

	// usb power always reports a full, changed level
	a_usb_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_USB |->
			out_data.level_changed && out_data.reported_percent == 8'd100)
		else $error("usb result not at full level");

	// an accepted level is a real percent
	a_accept_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_ACCEPT |->
			out_data.level_changed && out_data.reported_percent <= 8'd100)
		else $error("accepted level out of range");

	// pending or rejected samples never report a change
	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_PENDING || out_data.status == ST_REJECT) |->
			!out_data.level_changed)
		else $error("level change flagged without acceptance");

endmodule

bind battery_gauge_with_debounce_top bgd_checker u_bgd_checker (.*);
